// File: design/ofm_pkg.sv
// Package for the open-loop FOC modulator: widths, register codes, reset values,
// controller/datapath command types and the sine table generator.
// No dependencies.
`default_nettype none

package ofm_pkg;

  localparam int unsigned ANGLE_BITS_DEF      = 16;
  localparam int unsigned SINE_TABLE_BITS_DEF = 8;
  localparam int unsigned DUTY_BITS_DEF       = 10;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_POLE_CNT      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_ANGLE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLTAGE_RATIO = 2'd2;

  localparam logic [6:0]  POLE_CNT_RST      = 7'd7;
  localparam logic [15:0] ZERO_ANGLE_RST    = 16'd0;
  localparam logic [15:0] VOLTAGE_RATIO_RST = 16'd21845;

  // 2^56 / (256e6 * 2*pi): Q.8 rad*us to turns
  localparam logic [25:0] STEP_K         = 26'd44798134;
  localparam logic [16:0] SQRT3_HALF_Q16 = 17'd56756;
  localparam logic [63:0] HALF_PI_Q30    = 64'd1686629713;

  localparam int unsigned SERIES_DIV [10] = '{6, 20, 42, 72, 110, 156, 210, 272, 342, 420};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LO,
    ST_HI,
    ST_ANGLE,
    ST_ELEC,
    ST_LUT,
    ST_COS,
    ST_RS,
    ST_RM1,
    ST_RM2,
    ST_DUTY
  } ofm_state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_VEL,
    OP_LO,
    OP_HI,
    OP_ANGLE,
    OP_ELEC,
    OP_LUT,
    OP_COS,
    OP_RS,
    OP_RM1,
    OP_RM2,
    OP_DUTY
  } ofm_op_e;

  typedef struct packed {
    ofm_op_e op;
    logic    load_out;
  } ofm_cmd_t;

  // Unsigned Q0.15 sine of idx * (pi/2) / 2^tbits, Taylor series at Q30; elaboration only
  function automatic logic [14:0] sine_entry(input int unsigned idx, input int unsigned tbits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    longint      q15;
    x    = (HALF_PI_Q30 * 64'(idx)) >> tbits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int k = 1; k <= 10; k++) begin
      term = ((term * x2) >> 30) / 64'(SERIES_DIV[k-1]);
      if ((k & 1) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    q15 = (sum + longint'(1 << 14)) >>> 15;
    if (q15 > 32767) begin
      q15 = 32767;
    end
    return q15[14:0];
  endfunction

endpackage

`default_nettype wire

// File: design/ofm_in_if.sv
// Input channel of the open-loop FOC modulator: valid/ready plus the update word.
// Depends on nothing.
`default_nettype none

interface ofm_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] vel_cmd;
  logic        [19:0] elapsed_us;

  modport source (output valid, output vel_cmd, output elapsed_us, input ready);
  modport sink   (input valid, input vel_cmd, input elapsed_us, output ready);
endinterface

`default_nettype wire

// File: design/ofm_out_if.sv
// Output channel of the open-loop FOC modulator: valid/ready plus duties and position.
// Depends on ofm_pkg for the default duty width.
`default_nettype none

interface ofm_out_if #(
  parameter int unsigned DUTY_BITS = ofm_pkg::DUTY_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [DUTY_BITS-1:0] duty_a;
  logic [DUTY_BITS-1:0] duty_b;
  logic [DUTY_BITS-1:0] duty_c;
  logic [15:0]          shaft_position;

  modport source (output valid, output duty_a, output duty_b, output duty_c,
                  output shaft_position, input ready);
  modport sink   (input valid, input duty_a, input duty_b, input duty_c,
                  input shaft_position, output ready);
endinterface

`default_nettype wire

// File: design/ofm_ctrl.sv
// Sequencer of the open-loop FOC modulator: walks one word through the datapath
// steps and owns the handshakes. Depends on ofm_pkg.
`default_nettype none

module ofm_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output ofm_pkg::ofm_cmd_t cmd_o
);
  import ofm_pkg::*;

  ofm_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    in_ready_o   = 1'b0;
    cmd_o.op       = OP_NONE;
    cmd_o.load_out = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_VEL;
          state_d  = ST_LO;
        end
      end
      ST_LO: begin
        cmd_o.op = OP_LO;
        state_d  = ST_HI;
      end
      ST_HI: begin
        cmd_o.op = OP_HI;
        state_d  = ST_ANGLE;
      end
      ST_ANGLE: begin
        cmd_o.op = OP_ANGLE;
        state_d  = ST_ELEC;
      end
      ST_ELEC: begin
        cmd_o.op = OP_ELEC;
        state_d  = ST_LUT;
      end
      ST_LUT: begin
        cmd_o.op = OP_LUT;
        state_d  = ST_COS;
      end
      ST_COS: begin
        cmd_o.op = OP_COS;
        state_d  = ST_RS;
      end
      ST_RS: begin
        cmd_o.op = OP_RS;
        state_d  = ST_RM1;
      end
      ST_RM1: begin
        cmd_o.op = OP_RM1;
        state_d  = ST_RM2;
      end
      ST_RM2: begin
        cmd_o.op = OP_RM2;
        state_d  = ST_DUTY;
      end
      ST_DUTY: begin
        cmd_o.op = OP_DUTY;
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// File: design/ofm_datapath.sv
// Datapath of the open-loop FOC modulator: config registers, shaft angle, one shared
// signed multiplier, sine table and duty formation. Depends on ofm_pkg.
`default_nettype none

module ofm_datapath #(
  parameter int unsigned ANGLE_BITS      = ofm_pkg::ANGLE_BITS_DEF,
  parameter int unsigned SINE_TABLE_BITS = ofm_pkg::SINE_TABLE_BITS_DEF,
  parameter int unsigned DUTY_BITS       = ofm_pkg::DUTY_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ofm_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ofm_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  ofm_pkg::ofm_cmd_t                 cmd_i,
  input  logic signed [15:0]                vel_cmd_i,
  input  logic [19:0]                       elapsed_us_i,
  output logic [DUTY_BITS-1:0]              duty_a_o,
  output logic [DUTY_BITS-1:0]              duty_b_o,
  output logic [DUTY_BITS-1:0]              duty_c_o,
  output logic [15:0]                       shaft_position_o
);
  import ofm_pkg::*;

  localparam int unsigned Sh       = 56 - ANGLE_BITS;
  localparam int unsigned QuarterN = 2 ** SINE_TABLE_BITS;
  localparam int unsigned TabLen   = QuarterN + 1;
  localparam int unsigned TIdxW    = SINE_TABLE_BITS + 1;
  localparam int unsigned PhaseW   = SINE_TABLE_BITS + 2;

  localparam logic signed [50:0] HalfQ47 = signed'(51'(1) << 46);
  localparam logic signed [50:0] OneQ47  = signed'(51'(1) << 47);

  localparam logic [1:0] QuadI   = 2'd0;
  localparam logic [1:0] QuadII  = 2'd1;
  localparam logic [1:0] QuadIII = 2'd2;

  // configuration
  logic [6:0]  pole_cnt_q;
  logic [15:0] zero_angle_q;
  logic [15:0] voltage_ratio_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pole_cnt_q      <= POLE_CNT_RST;
      zero_angle_q    <= ZERO_ANGLE_RST;
      voltage_ratio_q <= VOLTAGE_RATIO_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_POLE_CNT:      pole_cnt_q      <= cfg_data_i[6:0];
        CFG_ZERO_ANGLE:    zero_angle_q    <= cfg_data_i;
        CFG_VOLTAGE_RATIO: voltage_ratio_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sine quarter-wave table, built at elaboration
  logic [14:0] sine_rom [TabLen];

  for (genvar g = 0; g < TabLen; g++) begin : g_rom
    localparam logic [14:0] RomVal = sine_entry(g, SINE_TABLE_BITS);
    assign sine_rom[g] = RomVal;
  end

  // working registers
  logic signed [35:0]           prod_q;
  logic                         neg_q;
  logic [16:0]                  mh_q;
  logic [43:0]                  lo_q;
  logic [42:0]                  hi_q;
  logic [ANGLE_BITS-1:0]        angle_q, angle_d;
  logic [ANGLE_BITS-1:0]        ep_q;
  logic signed [15:0]           s_q, c_q, s_d, c_d;
  logic signed [33:0]           t_q;
  logic signed [33:0]           pa_q;
  logic signed [34:0]           m1_q, m2_q;
  logic signed [49:0]           pb_q, pc_q;

  // shared multiplier
  logic signed [18:0] mul_a;
  logic signed [34:0] mul_b;
  logic signed [53:0] mul_p;

  logic [35:0] mag_full;
  logic [34:0] mag;

  assign mag_full = prod_q[35] ? 36'(-prod_q) : 36'(prod_q);
  assign mag      = mag_full[34:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_VEL: begin
        mul_a = 19'(vel_cmd_i);
        mul_b = signed'({15'b0, elapsed_us_i});
      end
      OP_LO: begin
        mul_a = signed'({1'b0, mag[17:0]});
        mul_b = signed'(35'(STEP_K));
      end
      OP_HI: begin
        mul_a = signed'({2'b0, mh_q});
        mul_b = signed'(35'(STEP_K));
      end
      OP_ELEC: begin
        mul_a = signed'({12'b0, pole_cnt_q});
        mul_b = signed'(35'(angle_q));
      end
      OP_COS: begin
        mul_a = 19'(c_q);
        mul_b = signed'(35'(SQRT3_HALF_Q16));
      end
      OP_RS: begin
        mul_a = signed'({3'b0, voltage_ratio_q});
        mul_b = 35'(s_q);
      end
      OP_RM1: begin
        mul_a = signed'({3'b0, voltage_ratio_q});
        mul_b = m1_q;
      end
      OP_RM2: begin
        mul_a = signed'({3'b0, voltage_ratio_q});
        mul_b = m2_q;
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // angle step: round(|p| * K / 2^Sh), sign applied after
  logic [60:0]           step_sum;
  logic [ANGLE_BITS-1:0] step;

  assign step_sum = {hi_q, 18'b0} + 61'(lo_q) + (61'(1) << (Sh - 1));
  assign step     = step_sum[55:Sh];
  assign angle_d  = neg_q ? angle_q - step : angle_q + step;

  // electrical angle and table lookup
  logic [39:0]              zero_wide;
  logic [ANGLE_BITS-1:0]    elec;
  logic [ANGLE_BITS+13:0]   ph_wide;
  logic [PhaseW-1:0]        phase;
  logic [1:0]               quad;
  logic [SINE_TABLE_BITS-1:0] idx;
  logic signed [15:0]       tf, tr;

  assign zero_wide = {zero_angle_q, 24'b0} >> (40 - ANGLE_BITS);
  assign elec      = ep_q + zero_wide[ANGLE_BITS-1:0];
  assign ph_wide   = {elec, 14'b0} >> (ANGLE_BITS + 12 - SINE_TABLE_BITS);
  assign phase     = ph_wide[PhaseW-1:0];
  assign quad      = phase[PhaseW-1:SINE_TABLE_BITS];
  assign idx       = phase[SINE_TABLE_BITS-1:0];
  assign tf        = signed'({1'b0, sine_rom[{1'b0, idx}]});
  assign tr        = signed'({1'b0, sine_rom[TIdxW'(QuarterN) - {1'b0, idx}]});

  always_comb begin
    case (quad)
      QuadI: begin
        s_d = tf;
        c_d = tr;
      end
      QuadII: begin
        s_d = tr;
        c_d = -tf;
      end
      QuadIII: begin
        s_d = -tf;
        c_d = -tr;
      end
      default: begin
        s_d = -tr;
        c_d = tf;
      end
    endcase
  end

  // s * 2^15 in the mixing width
  logic signed [34:0] s_sh;
  assign s_sh = signed'({{4{s_q[15]}}, s_q, 15'b0});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q <= '0;
    end else if (cmd_i.op == OP_ANGLE) begin
      angle_q <= angle_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_VEL: prod_q <= mul_p[35:0];
      OP_LO: begin
        lo_q  <= 44'(mul_p[43:0]);
        neg_q <= prod_q[35];
        mh_q  <= mag[34:18];
      end
      OP_HI:   hi_q <= mul_p[42:0];
      OP_ELEC: ep_q <= mul_p[ANGLE_BITS-1:0];
      OP_LUT: begin
        s_q <= s_d;
        c_q <= c_d;
      end
      OP_COS: t_q <= mul_p[33:0];
      OP_RS: begin
        pa_q <= mul_p[33:0];
        m1_q <= 35'(t_q) + s_sh;
        m2_q <= s_sh - 35'(t_q);
      end
      OP_RM1: pb_q <= mul_p[49:0];
      OP_RM2: pc_q <= mul_p[49:0];
      default: ;
    endcase
  end

  // clamp to [0, 1] in Q47, scale by 2^DUTY_BITS-1, truncate
  function automatic logic [DUTY_BITS-1:0] duty_of(input logic signed [50:0] q);
    logic [47:0]           v;
    logic [47+DUTY_BITS:0] w;
    if (q[50]) begin
      v = '0;
    end else if (q > OneQ47) begin
      v = 48'(1) << 47;
    end else begin
      v = q[47:0];
    end
    w = {v, DUTY_BITS'(0)} - (48 + DUTY_BITS)'(v);
    return w[47+DUTY_BITS-1:47];
  endfunction

  logic signed [50:0] da, db, dc;

  assign da = HalfQ47 - (51'(pa_q) <<< 16);
  assign db = HalfQ47 + 51'(pb_q);
  assign dc = HalfQ47 + 51'(pc_q);

  logic [ANGLE_BITS+23:0] pos_wide;
  assign pos_wide = {angle_q, 24'b0} >> (ANGLE_BITS + 8);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      duty_a_o         <= duty_of(da);
      duty_b_o         <= duty_of(db);
      duty_c_o         <= duty_of(dc);
      shaft_position_o <= pos_wide[15:0];
    end
  end

endmodule

`default_nettype wire

// File: design/open_loop_foc_modulator_core.sv
// Open-loop sinusoidal FOC modulator, top level: sequencer plus datapath.
// Depends on ofm_pkg, ofm_in_if, ofm_out_if, ofm_ctrl and ofm_datapath.
//
// Usage:
//   in_word carries one update word (velocity command in Q7.8 rad/s, elapsed_us).
//   out_word returns one word per update: three phase duties and the new shaft
//   position. The cfg write port (cfg_we_i, cfg_idx_i, cfg_data_i) sets the pole
//   count, zero_angle and voltage_ratio; write it only while the block is idle.
//   The output register loads at the end of the final DUTY step, and out_word.valid
//   rises at that same edge. The multiplying steps share one signed multiplier,
//   which the sequencer walks through 11 steps, so a new word is taken only
//   after the last one has passed all of them, while the receiver keeps up.
//   in_word.ready is high only while the sequencer is idle. If a finished word
//   still waits in the output register, the next word is taken and worked on,
//   and only its final load holds until out_word.ready frees the register.
//   Reset clears the shaft angle to zero, restores the register reset values
//   (7 pole pairs, zero offset 0, ratio 21845) and empties the output register.
`default_nettype none

module open_loop_foc_modulator_core #(
  parameter int unsigned ANGLE_BITS      = ofm_pkg::ANGLE_BITS_DEF,
  parameter int unsigned SINE_TABLE_BITS = ofm_pkg::SINE_TABLE_BITS_DEF,
  parameter int unsigned DUTY_BITS       = ofm_pkg::DUTY_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ofm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ofm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  ofm_in_if.sink                         in_word,
  ofm_out_if.source                      out_word
);
  import ofm_pkg::*;

  ofm_cmd_t             cmd;
  logic [DUTY_BITS-1:0] duty_a, duty_b, duty_c;
  logic [15:0]          shaft_position;

  ofm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_word.valid),
    .in_ready_o  (in_word.ready),
    .out_valid_o (out_word.valid),
    .out_ready_i (out_word.ready),
    .cmd_o       (cmd)
  );

  ofm_datapath #(
    .ANGLE_BITS      (ANGLE_BITS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS),
    .DUTY_BITS       (DUTY_BITS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .cmd_i             (cmd),
    .vel_cmd_i         (in_word.vel_cmd),
    .elapsed_us_i      (in_word.elapsed_us),
    .duty_a_o          (duty_a),
    .duty_b_o          (duty_b),
    .duty_c_o          (duty_c),
    .shaft_position_o  (shaft_position)
  );

  assign out_word.duty_a         = duty_a;
  assign out_word.duty_b         = duty_b;
  assign out_word.duty_c         = duty_c;
  assign out_word.shaft_position = shaft_position;

endmodule

`default_nettype wire
